// ===== design/tcls_pkg.sv =====
// Shared types, constants and byte-class functions of the C token classifier.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tcls_pkg;

	localparam int MAX_WORD_DEF = 32;
	localparam int NUM_KW = 32;

	// token kinds as they appear on token_kind
	localparam logic [1:0] KIND_OP  = 2'd0;
	localparam logic [1:0] KIND_KEY = 2'd1;
	localparam logic [1:0] KIND_ID  = 2'd2;

	// keyword text, right-justified: last character in the low byte
	localparam logic [63:0] KW_TEXT [NUM_KW] = '{
		64'("auto"),     64'("break"),    64'("case"),     64'("char"),
		64'("const"),    64'("continue"), 64'("default"),  64'("do"),
		64'("double"),   64'("else"),     64'("enum"),     64'("extern"),
		64'("float"),    64'("for"),      64'("goto"),     64'("if"),
		64'("int"),      64'("long"),     64'("register"), 64'("return"),
		64'("short"),    64'("signed"),   64'("sizeof"),   64'("static"),
		64'("struct"),   64'("switch"),   64'("typedef"),  64'("union"),
		64'("unsigned"), 64'("void"),     64'("volatile"), 64'("while")
	};

	localparam logic [3:0] KW_LEN [NUM_KW] = '{
		4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
		4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
		4'd3, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6,
		4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4, 4'd8, 4'd5
	};

	// per-cell control of the character chain
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	function automatic logic is_word_byte(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			(c >= "0" && c <= "9") || c == "_";
	endfunction

	function automatic logic is_op_byte(input logic [7:0] c);
		return c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
			c == "=" || c == "<" || c == ">" || c == "!" || c == "&" ||
			c == "|" || c == "^";
	endfunction

	// can this operator open a two-character operator
	function automatic logic opens_pair(input logic [7:0] first);
		return first == "=" || first == "!" || first == "+" || first == "-" ||
			first == "&" || first == "|";
	endfunction

	function automatic logic pairs_with(input logic [7:0] first, input logic [7:0] second);
		logic res;
		res = 1'b0;
		if (first == "=")
			res = (second == "=") || (second == "+");
		else if (opens_pair(first))
			res = (second == "=");
		return res;
	endfunction

endpackage

// ===== design/tcls_cell.sv =====
// One character cell of the word chain: loads a new character or takes its
// neighbor's. Depends on tcls_pkg.
`timescale 1ns / 1ps

module tcls_cell (
	input  logic               clk,
	input  tcls_pkg::cell_ctl_t ctl,
	input  logic [7:0]         load_char,
	input  logic [7:0]         nbr_char,
	output logic [7:0]         char_q
);
	import tcls_pkg::*;

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			char_q <= load_char;
		end else if (ctl.shift) begin
			char_q <= nbr_char;
		end
	end

endmodule

// ===== design/tcls_kw_match.sv =====
// Incremental keyword matcher: one flag per keyword, narrowed as each word
// character is stored. Depends on tcls_pkg.
`timescale 1ns / 1ps

module tcls_kw_match #(
	parameter int MAX_WORD = tcls_pkg::MAX_WORD_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          append,
	input  logic [$clog2(MAX_WORD+1)-1:0] pos,
	input  logic [7:0]                    ch,
	output logic                          hit
);
	import tcls_pkg::*;

	localparam int LW = $clog2(MAX_WORD + 1);

	logic [NUM_KW-1:0] match_q;
	logic [NUM_KW-1:0] keep;
	logic [NUM_KW-1:0] len_eq;

	for (genvar k = 0; k < NUM_KW; k++) begin : g_kw
		logic [2:0] idx;
		logic [7:0] kch;
		// byte pos of keyword k, zero past its end
		assign idx = 3'(KW_LEN[k] - 4'd1) - pos[2:0];
		assign kch = (pos < LW'(KW_LEN[k])) ? KW_TEXT[k][{idx, 3'b000} +: 8] : 8'h00;
		assign keep[k] = (kch == ch);
		assign len_eq[k] = (pos == LW'(KW_LEN[k]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= '1;
		end else if (clear) begin
			match_q <= '1;
		end else if (append) begin
			match_q <= match_q & keep;
		end
	end

	assign hit = |(match_q & len_eq);

endmodule

// ===== design/c_token_classifier.sv =====
// Top level of the byte-serial C token classifier.
// Depends on tcls_pkg, tcls_cell and tcls_kw_match.
`timescale 1ns / 1ps

// Source bytes enter on the in channel; tokens leave one character per item
// on the out channel, classed operator, keyword or identifier, with
// token_end on each token's last character and run_end on the last item
// caused by one input byte. An accepted byte is buffered and decoded once
// the block is idle and the output register can take an item. A finished
// word leaves the chain of character cells at one character per cycle while
// out_ready does not stall it; a lone operator leaves as one item and a
// two-character operator as two. While a word or a pair drains, the next
// byte waits in the input buffer. Words longer than MAX_WORD are cut to
// MAX_WORD characters. Keyword matching runs as the word is stored, so the
// class is ready when the word is flushed. No clearing pass after reset;
// the block is ready as soon as reset is released.
module c_token_classifier #(
	parameter int MAX_WORD = tcls_pkg::MAX_WORD_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] char_out,
	output logic [1:0] token_kind,
	output logic       token_end,
	output logic       run_end
);
	import tcls_pkg::*;

	localparam int LW = $clog2(MAX_WORD + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;  // decode buffered byte
	localparam logic [1:0] ST_EMIT = 2'd1;  // drain word from the chain
	localparam logic [1:0] ST_OP2  = 2'd2;  // second char of a pair

	logic [1:0]    state_q;

	// input buffer
	logic          inbuf_valid_q;
	logic [7:0]    inbuf_char_q;
	logic          inbuf_eot_q;

	// lexer state
	logic [LW-1:0] word_len_q;
	logic [7:0]    pend_op_q;
	logic          pend_valid_q;
	logic [7:0]    op2_char_q;
	logic [1:0]    kind_q;

	// output register
	logic          out_valid_q;
	logic [7:0]    char_out_q;
	logic [1:0]    kind_out_q;
	logic          tok_end_q;
	logic          run_end_q;

	logic          can_load;
	logic          step_go;
	logic          emit_go;
	logic          op2_go;
	logic          pair;
	logic          normal;
	logic          do_flush;
	logic          do_append;
	logic          set_pend;
	logic          last_char;
	logic          kw_hit;

	logic          out_load;
	logic [7:0]    out_char;
	logic [1:0]    out_kind;
	logic          out_end;
	logic          out_run;

	cell_ctl_t     cell_ctl [MAX_WORD];
	logic [7:0]    cell_char [MAX_WORD];

	// output register can take a new item this cycle
	assign can_load = !out_valid_q || out_ready;

	assign step_go = (state_q == ST_IDLE) && inbuf_valid_q && can_load;
	assign emit_go = (state_q == ST_EMIT) && can_load;
	assign op2_go  = (state_q == ST_OP2) && can_load;

	assign in_ready = !inbuf_valid_q || step_go;

	// Decode of the buffered byte. A held operator and a nonempty word never
	// coexist in ST_IDLE, so a step emits from at most one of them.
	assign pair      = pend_valid_q && !inbuf_eot_q && pairs_with(pend_op_q, inbuf_char_q);
	assign normal    = !inbuf_eot_q && !pair;
	assign do_flush  = step_go && (word_len_q != '0) &&
		(inbuf_eot_q || (normal && !is_word_byte(inbuf_char_q)));
	assign set_pend  = step_go && normal && is_op_byte(inbuf_char_q);
	assign do_append = step_go && normal && is_word_byte(inbuf_char_q) &&
		(word_len_q < LW'(MAX_WORD));
	assign last_char = (word_len_q == LW'(1));

	// next output item
	always_comb begin
		out_load = 1'b0;
		out_char = pend_op_q;
		out_kind = KIND_OP;
		out_end  = 1'b1;
		out_run  = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (step_go && pend_valid_q) begin
					out_load = 1'b1;
					out_end  = !pair;
					out_run  = !pair;
				end
			end
			ST_EMIT: begin
				out_load = emit_go;
				out_char = cell_char[0];
				out_kind = kind_q;
				out_end  = last_char;
				out_run  = last_char;
			end
			ST_OP2: begin
				out_load = op2_go;
				out_char = op2_char_q;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			inbuf_valid_q <= 1'b0;
			word_len_q    <= '0;
			pend_valid_q  <= 1'b0;
			pend_op_q     <= 8'h00;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				inbuf_valid_q <= 1'b1;
			end else if (step_go) begin
				inbuf_valid_q <= 1'b0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			// held operator is used up by any step; a new one may replace it
			if (set_pend) begin
				pend_valid_q <= 1'b1;
				pend_op_q    <= inbuf_char_q;
			end else if (step_go) begin
				pend_valid_q <= 1'b0;
				pend_op_q    <= 8'h00;
			end

			if (do_append) begin
				word_len_q <= word_len_q + LW'(1);
			end else if (emit_go) begin
				word_len_q <= word_len_q - LW'(1);
			end

			unique case (state_q)
				ST_IDLE: begin
					if (step_go && pair) begin
						state_q <= ST_OP2;
					end else if (do_flush) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go && last_char) begin
						state_q <= ST_IDLE;
					end
				end
				ST_OP2: begin
					if (op2_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			inbuf_char_q <= char_in;
			inbuf_eot_q  <= end_of_text;
		end
		if (step_go && pair) begin
			op2_char_q <= inbuf_char_q;
		end
		if (do_flush) begin
			kind_q <= kw_hit ? KIND_KEY : KIND_ID;
		end
		if (out_load) begin
			char_out_q <= out_char;
			kind_out_q <= out_kind;
			tok_end_q  <= out_end;
			run_end_q  <= out_run;
		end
	end

	// character chain: append at the cell the length points to, drain
	// toward cell 0 one step per emitted character
	for (genvar i = 0; i < MAX_WORD; i++) begin : g_cell
		logic [7:0] nbr_char;
		if (i == MAX_WORD - 1) begin : g_tail
			assign nbr_char = 8'h00;
		end else begin : g_mid
			assign nbr_char = cell_char[i+1];
		end
		assign cell_ctl[i].load  = do_append && (word_len_q == LW'(i));
		assign cell_ctl[i].shift = emit_go;
		tcls_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[i]),
			.load_char (inbuf_char_q),
			.nbr_char  (nbr_char),
			.char_q    (cell_char[i])
		);
	end

	tcls_kw_match #(
		.MAX_WORD (MAX_WORD)
	) u_kw (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (emit_go && last_char),
		.append (do_append),
		.pos    (word_len_q),
		.ch     (inbuf_char_q),
		.hit    (kw_hit)
	);

	assign out_valid  = out_valid_q;
	assign char_out   = char_out_q;
	assign token_kind = kind_out_q;
	assign token_end  = tok_end_q;
	assign run_end    = run_end_q;

endmodule

// ===== design/tcls_checker.sv =====
// Port-level checks of the C token classifier, bound to the top level.
// Depends on tcls_pkg and c_token_classifier.
`timescale 1ns / 1ps

module tcls_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] char_out,
	input logic [1:0] token_kind,
	input logic       token_end,
	input logic       run_end
);
	import tcls_pkg::*;

	// a stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_out) &&
			$stable(token_kind) && $stable(token_end) && $stable(run_end))
		else $error("out item changed while stalled");

	// a run never ends inside a token
	a_run_in_tok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && run_end |-> token_end)
		else $error("run_end without token_end");

	// words carry only word characters
	a_word_chars: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != KIND_OP |-> is_word_byte(char_out))
		else $error("non-word character in word token");

	// operators carry operator bytes; only a pair opener leaves one open
	a_op_chars: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_OP |->
			is_op_byte(char_out) && (token_end || opens_pair(char_out)))
		else $error("bad operator character");

endmodule

bind c_token_classifier tcls_checker u_tcls_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.char_out   (char_out),
	.token_kind (token_kind),
	.token_end  (token_end),
	.run_end    (run_end)
);
